// File: rtl/core/clf_pkg.sv
// shared types and constants of the crlf line framer
`default_nettype none

package clf_pkg;

    // framing bytes
    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] LF_BYTE = 8'h0A;

    // largest line that store_index and line_length can express
    localparam int FIELD_CAP    = 256;
    localparam int LINE_MAX_DEF = 256;

    // result status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_CR      = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_ERROR   = 3'd4;
    localparam logic [2:0] ST_RESTART = 3'd5;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] byte_out;
        logic [7:0] store_index;
        logic [8:0] line_length;
    } res_item_t;

endpackage

`default_nettype wire

// File: rtl/core/clf_if.sv
// stream channel interfaces of the crlf line framer
`default_nettype none

interface clf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface clf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] byte_out;
    logic [7:0] store_index;
    logic [8:0] line_length;

    modport source (output valid, output status, output byte_out, output store_index,
                    output line_length, input ready);
    modport sink   (input valid, input status, input byte_out, input store_index,
                    input line_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/clf_in_stage.sv
// input register stage of the crlf line framer
`default_nettype none

module clf_in_stage (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  clf_pkg::in_item_t in_item,
    output logic              item_valid,
    input  wire               item_take,
    output clf_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    clf_pkg::in_item_t item_reg;

    // space when empty or when the held item moves on this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/clf_core.sv
// line framing state machine of the crlf line framer
`default_nettype none

module clf_core #(
    parameter int LINE_MAX = clf_pkg::LINE_MAX_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                advance,
    input  clf_pkg::in_item_t  item,
    output clf_pkg::res_item_t res
);

    localparam int         LIMIT   = (LINE_MAX > clf_pkg::FIELD_CAP) ? clf_pkg::FIELD_CAP
                                                                    : LINE_MAX;
    localparam logic [8:0] LIMIT_W = 9'(LIMIT);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONTENT = 2'd1,
        PH_SAWCR   = 2'd2
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [8:0] count_reg;
    logic [8:0] count_next;

    logic is_cr;
    logic is_lf;
    logic room;

    assign is_cr = (item.in_byte == clf_pkg::CR_BYTE);
    assign is_lf = (item.in_byte == clf_pkg::LF_BYTE);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        room       = 1'b0;
        res        = '0;
        res.status = clf_pkg::ST_ERROR;

        if (item.mode)
        begin
            phase_next = PH_IDLE;
            count_next = '0;
            res.status = clf_pkg::ST_RESTART;
        end
        else
        begin
            unique case (phase_reg)
                PH_CONTENT:
                begin
                    room = (count_reg < LIMIT_W);
                    if (is_cr)
                    begin
                        phase_next = PH_SAWCR;
                        res.status = clf_pkg::ST_CR;
                    end
                    else if (!is_lf)
                    begin
                        if (room)
                        begin
                            res.status      = clf_pkg::ST_STORED;
                            res.byte_out    = item.in_byte;
                            res.store_index = count_reg[7:0];
                            count_next      = count_reg + 9'd1;
                        end
                        else
                        begin
                            res.status = clf_pkg::ST_DROPPED;
                        end
                    end
                end
                PH_SAWCR:
                begin
                    if (is_lf)
                    begin
                        phase_next      = PH_IDLE;
                        res.status      = clf_pkg::ST_DONE;
                        res.line_length = count_reg;
                    end
                end
                default:
                begin
                    // idle, and the unused code treated as idle; limit is at least one
                    if (is_cr)
                    begin
                        phase_next = PH_SAWCR;
                        count_next = '0;
                        res.status = clf_pkg::ST_CR;
                    end
                    else if (!is_lf)
                    begin
                        phase_next      = PH_CONTENT;
                        count_next      = 9'd1;
                        res.status      = clf_pkg::ST_STORED;
                        res.byte_out    = item.in_byte;
                        res.store_index = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/clf_out_stage.sv
// result register stage of the crlf line framer
`default_nettype none

module clf_out_stage (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                res_load,
    output logic               res_space,
    input  clf_pkg::res_item_t res_in,
    output logic               out_valid,
    input  wire                out_ready,
    output clf_pkg::res_item_t res_out
);

    logic               valid_reg;
    logic               valid_next;
    clf_pkg::res_item_t res_reg;

    assign res_space  = !valid_reg || out_ready;
    assign valid_next = res_load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/crlf_line_framer.sv
// top level of the crlf line framer
//
//  channel   dir  payload                                          handshake
//  in_ch     in   mode, in_byte                                    valid / ready
//  out_ch    out  status, byte_out, store_index, line_length       valid / ready
//
// one result item for every input item, one item per cycle sustained while out_ch is not stalled
// each item passes the input register, then the framing logic into the result register
// the phase and line count advance in the cycle the held item moves into the result register
// rst_n clears the valid bits, the phase (idle) and the line count; payload registers are not reset
// a stall on out_ch holds the result; the input register still fills, so one new item is
// taken while a finished result waits
`default_nettype none

module crlf_line_framer #(
    parameter int LINE_MAX = clf_pkg::LINE_MAX_DEF
) (
    input  wire      clk,
    input  wire      rst_n,
    clf_in_if.sink   in_ch,
    clf_out_if.source out_ch
);

    clf_pkg::in_item_t  in_item;
    clf_pkg::in_item_t  held_item;
    clf_pkg::res_item_t res_next;
    clf_pkg::res_item_t res_out;
    logic               held_valid;
    logic               res_space;
    logic               advance;

    assign in_item.mode    = in_ch.mode;
    assign in_item.in_byte = in_ch.in_byte;

    // held item moves on when the result register has room
    assign advance = held_valid && res_space;

    clf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .item_valid (held_valid),
        .item_take  (advance),
        .item       (held_item)
    );

    // phase, line count and per-byte decision
    clf_core #(
        .LINE_MAX (LINE_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .res     (res_next)
    );

    clf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (advance),
        .res_space (res_space),
        .res_in    (res_next),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .res_out   (res_out)
    );

    assign out_ch.status      = res_out.status;
    assign out_ch.byte_out    = res_out.byte_out;
    assign out_ch.store_index = res_out.store_index;
    assign out_ch.line_length = res_out.line_length;

    // an item leaving the input register always shows up as a result next cycle
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_ch.valid)
        else $error("advanced item produced no result");

    // a restart item yields the restart status
    a_restart_status: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && held_item.mode) |=> (out_ch.status == clf_pkg::ST_RESTART))
        else $error("restart item gave wrong status");

    // reported line length never exceeds the field cap
    a_length_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.line_length <= 9'(clf_pkg::FIELD_CAP)))
        else $error("line length beyond cap");

    // only a stored byte carries byte and index (the line length is not part of this check)
    a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status != clf_pkg::ST_STORED))
            |-> (out_ch.byte_out == 8'd0 && out_ch.store_index == 8'd0))
        else $error("stray byte or index on non-store result");

endmodule

`default_nettype wire

// File: bench/line_frame_checker.sv
// monitor, line framing predictor and result comparison for the crlf line framer
`timescale 1ns / 100ps

module line_frame_checker #(
    parameter int LINE_MAX = clf_pkg::LINE_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    clf_in_if           in_ch,
    clf_out_if          out_ch,
    output int unsigned fails,
    output int unsigned pending,
    output int unsigned lines_done,
    output int unsigned drops_seen,
    output int unsigned errors_seen,
    output int unsigned restarts_seen
);
    import clf_pkg::*;

    localparam int STORE_CAP = (LINE_MAX > FIELD_CAP) ? FIELD_CAP : LINE_MAX;

    typedef enum logic [1:0] {
        FR_IDLE    = 2'd0,
        FR_CONTENT = 2'd1,
        FR_SAWCR   = 2'd2
    } frame_phase_t;

    frame_phase_t fr_phase;
    logic [8:0]   fr_count;
    res_item_t    frames_due[$];

    // content byte: stored at the next index, or dropped once the line is full
    function automatic res_item_t keep_byte(input logic [7:0] b);
        res_item_t r;
        r = '0;
        if (fr_count < STORE_CAP)
        begin
            r.status      = ST_STORED;
            r.byte_out    = b;
            r.store_index = fr_count[7:0];
            fr_count      = fr_count + 9'd1;
        end
        else
        begin
            r.status = ST_DROPPED;
        end
        return r;
    endfunction

    function automatic res_item_t frame_byte(input logic m, input logic [7:0] b);
        res_item_t r;
        r = '0;
        if (m)
        begin
            fr_phase = FR_IDLE;
            fr_count = '0;
            r.status = ST_RESTART;
        end
        else if (fr_phase == FR_CONTENT)
        begin
            if (b == CR_BYTE)
            begin
                fr_phase = FR_SAWCR;
                r.status = ST_CR;
            end
            else if (b == LF_BYTE)
                r.status = ST_ERROR;
            else
                r = keep_byte(b);
        end
        else if (fr_phase == FR_SAWCR)
        begin
            if (b == LF_BYTE)
            begin
                r.status      = ST_DONE;
                r.line_length = fr_count;
                fr_phase      = FR_IDLE;
            end
            else
                r.status = ST_ERROR;
        end
        else
        begin
            if (b == CR_BYTE)
            begin
                fr_count = '0;
                fr_phase = FR_SAWCR;
                r.status = ST_CR;
            end
            else if (b == LF_BYTE)
                r.status = ST_ERROR;
            else
            begin
                fr_count = '0;
                fr_phase = FR_CONTENT;
                r = keep_byte(b);
            end
        end
        return r;
    endfunction

    task automatic flag_field(input string what, input logic [8:0] want, input logic [8:0] got);
        fails++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            fr_phase = FR_IDLE;
            fr_count = '0;
            frames_due.delete();
            pending <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: result with nothing outstanding, got status %0d",
                             $time, out_ch.status);
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (out_ch.status !== want.status)
                        flag_field("status", 9'(want.status), 9'(out_ch.status));
                    if (out_ch.byte_out !== want.byte_out)
                        flag_field("byte_out", 9'(want.byte_out), 9'(out_ch.byte_out));
                    if (out_ch.store_index !== want.store_index)
                        flag_field("store_index", 9'(want.store_index),
                                   9'(out_ch.store_index));
                    if (out_ch.line_length !== want.line_length)
                        flag_field("line_length", want.line_length, out_ch.line_length);
                    case (want.status)
                        ST_DONE:    lines_done++;
                        ST_DROPPED: drops_seen++;
                        ST_ERROR:   errors_seen++;
                        ST_RESTART: restarts_seen++;
                        default:    ;
                    endcase
                end
            end
            if (in_ch.valid && in_ch.ready)
                frames_due.push_back(frame_byte(in_ch.mode, in_ch.in_byte));
            pending <= frames_due.size();
        end
    end

endmodule

// File: bench/testbench.sv
// top of the crlf line framer bench: clock, reset, stimulus, stall patterns and verdict
`timescale 1ns / 100ps

module testbench;
    import clf_pkg::*;

    localparam int LINE_MAX  = LINE_MAX_DEF;
    // most bytes a line can keep before the framer starts dropping
    localparam int STORE_CAP = (LINE_MAX > FIELD_CAP) ? FIELD_CAP : LINE_MAX;

    localparam int unsigned ITEM_GOAL   = 1375;    // directed plus about 1350 random items
    localparam int unsigned CALM_TAIL   = 150;     // last items run with no idling at all
    localparam int unsigned HOLD_CYCLES = 40;      // long receiver hold-off
    localparam int unsigned DRAIN       = 8;       // settle time after the last result
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;

    clf_in_if  in_ch();
    clf_out_if out_ch();

    int unsigned fails;
    int unsigned pending;
    int unsigned lines_done;
    int unsigned drops_seen;
    int unsigned errors_seen;
    int unsigned restarts_seen;
    int unsigned items_sent;
    int unsigned cycles;

    bit calm;       // no idling on either side
    bit no_gaps;    // sender offers back to back
    bit hold_req;   // asks the receiver for one long hold-off

    crlf_line_framer #(
        .LINE_MAX (LINE_MAX)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // watches both channels, predicts each result and compares it
    line_frame_checker #(
        .LINE_MAX (LINE_MAX)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fails         (fails),
        .pending       (pending),
        .lines_done    (lines_done),
        .drops_seen    (drops_seen),
        .errors_seen   (errors_seen),
        .restarts_seen (restarts_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // safety net against a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: ready bursts and low bursts of random length,
    // a long hold-off on request, always ready in the calm tail
    initial
    begin
        int unsigned left;
        logic        lvl;
        left = 0;
        lvl  = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                lvl      = 1'b0;
                left     = HOLD_CYCLES;
            end
            else if (left == 0)
            begin
                if (!calm && $urandom_range(0, 4) == 0)
                begin
                    lvl  = 1'b0;
                    left = $urandom_range(1, 14);
                end
                else
                begin
                    lvl  = 1'b1;
                    left = $urandom_range(1, 20);
                end
            end
            out_ch.ready <= lvl;
            left--;
        end
    end

    // a byte that is neither CR nor LF
    function automatic logic [7:0] line_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CR_BYTE || b == LF_BYTE);
        return b;
    endfunction

    // offers one item, sometimes after an idle burst, and returns at the edge that takes it
    task automatic offer(input logic m, input logic [7:0] b);
        if (!calm && !no_gaps && $urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= m;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // random content closed by CR LF
    task automatic send_line(input int unsigned len);
        repeat (len) offer(1'b0, line_char());
        offer(1'b0, CR_BYTE);
        offer(1'b0, LF_BYTE);
    endtask

    initial
    begin
        int unsigned line_no;
        int unsigned pick;
        line_no = 0;
        rst_n   = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= 1'b0;
        in_ch.in_byte <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: restart, bare LF, empty line, missing LF, byte extremes,
        // bare LF inside a line, restart mid-line and in the saw-CR phase
        offer(1'b1, 8'hFF);
        offer(1'b0, LF_BYTE);
        offer(1'b0, CR_BYTE);
        offer(1'b0, CR_BYTE);
        offer(1'b0, 8'h00);
        offer(1'b0, LF_BYTE);
        offer(1'b0, 8'h00);
        offer(1'b0, 8'hFF);
        offer(1'b0, LF_BYTE);
        offer(1'b0, 8'h0B);
        offer(1'b0, 8'h0C);
        offer(1'b0, CR_BYTE);
        offer(1'b0, LF_BYTE);
        offer(1'b0, 8'h80);
        offer(1'b0, 8'h7F);
        offer(1'b1, CR_BYTE);
        offer(1'b0, LF_BYTE);
        offer(1'b0, CR_BYTE);
        offer(1'b1, 8'h00);
        offer(1'b0, 8'h09);
        offer(1'b0, CR_BYTE);
        offer(1'b0, LF_BYTE);
        offer(1'b1, LF_BYTE);

        // random: mostly well formed lines, with restarts, broken endings and noise
        while (items_sent < ITEM_GOAL)
        begin
            calm = (items_sent + CALM_TAIL >= ITEM_GOAL);
            line_no++;
            if (line_no == 3)
                send_line(STORE_CAP);                            // exactly full line
            else if (line_no == 20)
                send_line(STORE_CAP + $urandom_range(1, 6));     // overflowing line
            else if (line_no == 10)
            begin
                // receiver stalls while the sender keeps pushing, filling the block
                no_gaps  = 1'b1;
                hold_req = 1'b1;
                send_line(24);
                no_gaps  = 1'b0;
            end
            else if (line_no == 30)
            begin
                // sender goes quiet until every outstanding result has drained
                in_ch.valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
                send_line($urandom_range(0, 12));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                    send_line($urandom_range(0, 12));
                else if (pick < 80)
                begin
                    // restart partway through a line
                    repeat ($urandom_range(0, 6)) offer(1'b0, line_char());
                    if ($urandom_range(0, 1) == 1)
                        offer(1'b0, CR_BYTE);
                    offer(1'b1, 8'($urandom_range(0, 255)));
                end
                else if (pick < 88)
                begin
                    // CR followed by junk before the LF finally arrives
                    repeat ($urandom_range(0, 6)) offer(1'b0, line_char());
                    offer(1'b0, CR_BYTE);
                    repeat ($urandom_range(1, 3))
                        offer(1'b0, ($urandom_range(0, 1) == 1) ? CR_BYTE : line_char());
                    offer(1'b0, LF_BYTE);
                end
                else if (pick < 94)
                begin
                    // stray LF inside a line
                    repeat ($urandom_range(1, 5)) offer(1'b0, line_char());
                    offer(1'b0, LF_BYTE);
                    send_line($urandom_range(0, 4));
                end
                else
                begin
                    // raw noise
                    repeat ($urandom_range(1, 4))
                        offer($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
                end
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);

        $display("sent %0d items: %0d lines completed, %0d bytes dropped on long lines,",
                 items_sent, lines_done, drops_seen);
        $display("%0d framing errors, %0d restarts, %0d mismatches",
                 errors_seen, restarts_seen, fails);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
